/* src/nfcdf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfcdf_pkg
// shared widths, register indexes, status codes and reset values of the
// frame deframer
// ----------------------------------------------------------------------------
package nfcdf_pkg;

    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 3;
    localparam int CFG_IDX_W = 1;

    typedef logic [BYTE_W-1:0]   byte_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // configuration register indexes
    localparam cfg_idx_t REG_MAX_PAYLOAD = 1'd0;
    localparam cfg_idx_t REG_EXPECTED_ID = 1'd1;

    // frame status codes
    localparam status_t ST_OK        = 3'd0;
    localparam status_t ST_BAD_START = 3'd1;
    localparam status_t ST_BAD_LCS   = 3'd2;
    localparam status_t ST_TOO_LONG  = 3'd3;
    localparam status_t ST_BAD_TFI   = 3'd4;
    localparam status_t ST_ERR_FRAME = 3'd5;
    localparam status_t ST_BAD_DCS   = 3'd6;
    localparam status_t ST_BAD_POST  = 3'd7;

    // register reset values
    localparam byte_t MAX_PAYLOAD_RST = 8'd64;
    localparam byte_t EXPECTED_ID_RST = 8'hD5;

endpackage

/* src/nfcdf_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfcdf_in_if
// received byte channel: start flag and byte with valid/ready
// ----------------------------------------------------------------------------
interface nfcdf_in_if;
    import nfcdf_pkg::*;

    logic  valid;
    logic  ready;
    logic  frame_start;
    byte_t rx_byte;

    modport source (output valid, output frame_start, output rx_byte, input ready);
    modport sink   (input valid, input frame_start, input rx_byte, output ready);
endinterface

/* src/nfcdf_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfcdf_out_if
// result channel: payload bytes and frame status with valid/ready
// ----------------------------------------------------------------------------
interface nfcdf_out_if;
    import nfcdf_pkg::*;

    logic    valid;
    logic    ready;
    logic    result_kind;
    byte_t   payload_byte;
    byte_t   payload_index;
    status_t frame_status;
    byte_t   frame_length;
    byte_t   fault_code;
    logic    is_last;

    modport source (
        output valid, output result_kind, output payload_byte, output payload_index,
        output frame_status, output frame_length, output fault_code, output is_last,
        input ready
    );
    modport sink (
        input valid, input result_kind, input payload_byte, input payload_index,
        input frame_status, input frame_length, input fault_code, input is_last,
        output ready
    );
endinterface

/* src/nfc_frame_deframer_core.sv */
`timescale 1ns / 1ps
// path: an accepted byte passes the input register, then the result register
// throughput: one byte per cycle unless the result channel stalls, set by the
//   single-pass parser between the input register and the result register
// reset: rst_n asynchronous active low; parser waits for a frame start,
//   limits return to 64 bytes and identifier 0xd5
// ----------------------------------------------------------------------------
// nfc_frame_deframer_core
// byte-wise deframer for reader controller information frames
// ----------------------------------------------------------------------------
module nfc_frame_deframer_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  nfcdf_pkg::cfg_idx_t cfg_index,
    input  nfcdf_pkg::byte_t    cfg_data,
    nfcdf_in_if.sink            item,
    nfcdf_out_if.source         result
);
    import nfcdf_pkg::*;

    // parser phases
    localparam logic [3:0] PH_WAIT   = 4'd0;
    localparam logic [3:0] PH_START1 = 4'd1;
    localparam logic [3:0] PH_START2 = 4'd2;
    localparam logic [3:0] PH_LEN    = 4'd3;
    localparam logic [3:0] PH_LCS    = 4'd4;
    localparam logic [3:0] PH_TFI    = 4'd5;
    localparam logic [3:0] PH_ECODE  = 4'd6;
    localparam logic [3:0] PH_EPOST  = 4'd7;
    localparam logic [3:0] PH_DATA   = 4'd8;
    localparam logic [3:0] PH_DCS    = 4'd9;
    localparam logic [3:0] PH_POST   = 4'd10;

    // byte values of the frame layout
    localparam byte_t PREAMBLE   = 8'h00;
    localparam byte_t START_HI   = 8'hFF;
    localparam byte_t POSTAMBLE  = 8'h00;
    localparam byte_t ERROR_TFI  = 8'h7F;

    // configuration registers
    byte_t max_payload_reg;
    byte_t expected_id_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg <= MAX_PAYLOAD_RST;
            expected_id_reg <= EXPECTED_ID_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_MAX_PAYLOAD: max_payload_reg <= cfg_data;
                REG_EXPECTED_ID: expected_id_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // input register stage: one transaction held until the parser takes it
    logic  in_valid_reg;
    logic  in_start_reg;
    byte_t in_byte_reg;

    // result register stage
    logic    out_valid_reg;
    logic    out_kind_reg;
    byte_t   out_byte_reg;
    byte_t   out_index_reg;
    status_t out_status_reg;
    byte_t   out_length_reg;
    byte_t   out_code_reg;
    logic    out_last_reg;

    // the parser consumes the held byte when the result slot is free or draining
    logic advance;
    assign advance    = in_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            in_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.ready && item.valid)
        begin
            in_start_reg <= item.frame_start;
            in_byte_reg  <= item.rx_byte;
        end
    end

    // parser state
    logic [3:0] phase_reg, phase_next;
    byte_t      length_reg, length_next;
    byte_t      count_reg, count_next;
    byte_t      sum_reg, sum_next;
    byte_t      code_reg, code_next;

    // combinational result of this byte
    logic    emit;
    logic    res_kind;
    byte_t   res_byte;
    byte_t   res_index;
    status_t res_status;
    byte_t   res_length;
    byte_t   res_code;

    // payload length after the identifier; zero length reads as empty
    byte_t payload_len;
    byte_t count_inc;
    assign payload_len = (length_reg == '0) ? '0 : length_reg - 8'd1;
    assign count_inc   = count_reg + 8'd1;

    always_comb
    begin
        phase_next  = phase_reg;
        length_next = length_reg;
        count_next  = count_reg;
        sum_next    = sum_reg;
        code_next   = code_reg;
        emit        = 1'b0;
        res_kind    = 1'b1;
        res_byte    = '0;
        res_index   = '0;
        res_status  = ST_OK;
        res_length  = '0;
        res_code    = '0;

        if (in_start_reg)
        begin
            // new frame: clear counters, this byte is the preamble
            length_next = '0;
            count_next  = '0;
            sum_next    = '0;
            code_next   = '0;
            if (in_byte_reg != PREAMBLE)
            begin
                emit       = 1'b1;
                res_status = ST_BAD_START;
                phase_next = PH_WAIT;
            end
            else
            begin
                phase_next = PH_START1;
            end
        end
        else
        begin
            case (phase_reg)
                PH_START1:
                begin
                    if (in_byte_reg != PREAMBLE)
                    begin
                        emit       = 1'b1;
                        res_status = ST_BAD_START;
                        phase_next = PH_WAIT;
                    end
                    else
                    begin
                        phase_next = PH_START2;
                    end
                end
                PH_START2:
                begin
                    if (in_byte_reg != START_HI)
                    begin
                        emit       = 1'b1;
                        res_status = ST_BAD_START;
                        phase_next = PH_WAIT;
                    end
                    else
                    begin
                        phase_next = PH_LEN;
                    end
                end
                PH_LEN:
                begin
                    length_next = in_byte_reg;
                    phase_next  = PH_LCS;
                end
                PH_LCS:
                begin
                    // length checksum first, then the payload limit
                    if (byte_t'(in_byte_reg + length_reg) != '0)
                    begin
                        emit       = 1'b1;
                        res_status = ST_BAD_LCS;
                        phase_next = PH_WAIT;
                    end
                    else if (payload_len > max_payload_reg)
                    begin
                        emit       = 1'b1;
                        res_status = ST_TOO_LONG;
                        phase_next = PH_WAIT;
                    end
                    else
                    begin
                        phase_next = PH_TFI;
                    end
                end
                PH_TFI:
                begin
                    if (in_byte_reg != expected_id_reg)
                    begin
                        if (in_byte_reg == ERROR_TFI)
                        begin
                            phase_next = PH_ECODE;
                        end
                        else
                        begin
                            emit       = 1'b1;
                            res_status = ST_BAD_TFI;
                            phase_next = PH_WAIT;
                        end
                    end
                    else
                    begin
                        // data checksum starts with the identifier
                        sum_next   = in_byte_reg;
                        count_next = '0;
                        phase_next = (payload_len == '0) ? PH_DCS : PH_DATA;
                    end
                end
                PH_ECODE:
                begin
                    code_next  = in_byte_reg;
                    phase_next = PH_EPOST;
                end
                PH_EPOST:
                begin
                    // error frame reported whatever the postamble holds
                    emit       = 1'b1;
                    res_status = ST_ERR_FRAME;
                    res_code   = code_reg;
                    phase_next = PH_WAIT;
                end
                PH_DATA:
                begin
                    emit       = 1'b1;
                    res_kind   = 1'b0;
                    res_byte   = in_byte_reg;
                    res_index  = count_reg;
                    sum_next   = sum_reg + in_byte_reg;
                    count_next = count_inc;
                    if (count_inc >= payload_len)
                    begin
                        phase_next = PH_DCS;
                    end
                end
                PH_DCS:
                begin
                    if (byte_t'(in_byte_reg + sum_reg) != '0)
                    begin
                        emit       = 1'b1;
                        res_status = ST_BAD_DCS;
                        phase_next = PH_WAIT;
                    end
                    else
                    begin
                        phase_next = PH_POST;
                    end
                end
                PH_POST:
                begin
                    emit       = 1'b1;
                    phase_next = PH_WAIT;
                    if (in_byte_reg != POSTAMBLE)
                    begin
                        res_status = ST_BAD_POST;
                    end
                    else
                    begin
                        res_status = ST_OK;
                        res_length = length_reg;
                    end
                end
                default:
                begin
                    // waiting and unused codes ignore the byte
                    phase_next = PH_WAIT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_WAIT;
            length_reg <= '0;
            count_reg  <= '0;
            sum_reg    <= '0;
            code_reg   <= '0;
        end
        else if (advance)
        begin
            phase_reg  <= phase_next;
            length_reg <= length_next;
            count_reg  <= count_next;
            sum_reg    <= sum_next;
            code_reg   <= code_next;
        end
    end

    // result register: loaded when a result is produced, cleared once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= emit;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_kind_reg   <= res_kind;
            out_byte_reg   <= res_byte;
            out_index_reg  <= res_index;
            out_status_reg <= res_status;
            out_length_reg <= res_length;
            out_code_reg   <= res_code;
            out_last_reg   <= res_kind;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.result_kind   = out_kind_reg;
    assign result.payload_byte  = out_byte_reg;
    assign result.payload_index = out_index_reg;
    assign result.frame_status  = out_status_reg;
    assign result.frame_length  = out_length_reg;
    assign result.fault_code    = out_code_reg;
    assign result.is_last       = out_last_reg;

endmodule

/* verif/nfc_frame_deframer_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfc_frame_deframer_checker
// follows every transaction on both channels, keeps its own parser model of
// the deframer and compares each result with the oldest prediction
// ----------------------------------------------------------------------------
module nfc_frame_deframer_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  nfcdf_pkg::cfg_idx_t cfg_index,
    input  nfcdf_pkg::byte_t    cfg_data,
    nfcdf_in_if                 item,
    nfcdf_out_if                result,
    output int                  mismatches,
    output int                  outstanding
);
    import nfcdf_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_SYNC0,
        PH_SYNC1,
        PH_LEN,
        PH_LEN_CSUM,
        PH_IDENT,
        PH_ERR_CODE,
        PH_ERR_POST,
        PH_BODY,
        PH_BODY_CSUM,
        PH_POSTAMBLE
    } parse_phase_e;

    localparam byte_t ERROR_IDENT = 8'h7F;
    localparam byte_t PREAMBLE    = 8'h00;
    localparam byte_t START_CODE  = 8'hFF;
    localparam int    REPORT_MAX  = 10;

    typedef struct packed {
        logic    kind;
        byte_t   data;
        byte_t   index;
        status_t status;
        byte_t   length;
        byte_t   code;
        logic    last;
    } deframed_t;

    byte_t        max_body;
    byte_t        want_ident;
    parse_phase_e phase;
    byte_t        len_field;
    byte_t        body_count;
    byte_t        data_sum;
    byte_t        err_code;
    deframed_t    deframed_q[$];
    int           err_total;

    assign mismatches = err_total;

    function automatic byte_t body_len();
        return (len_field == 8'd0) ? 8'd0 : byte_t'(len_field - 8'd1);
    endfunction

    function automatic void close_frame(input status_t st, input byte_t len,
                                        input byte_t code);
        deframed_t r;
        r        = '0;
        r.kind   = 1'b1;
        r.status = st;
        r.length = len;
        r.code   = code;
        r.last   = 1'b1;
        deframed_q.push_back(r);
        phase = PH_IDLE;
    endfunction

    function automatic void deframe_byte(input logic start, input byte_t b);
        deframed_t r;
        byte_t     tally;
        if (start)
        begin
            len_field  = 8'd0;
            body_count = 8'd0;
            data_sum   = 8'd0;
            err_code   = 8'd0;
            if (b != PREAMBLE)
                close_frame(ST_BAD_START, 8'd0, 8'd0);
            else
                phase = PH_SYNC0;
        end
        else
        begin
            case (phase)
                PH_SYNC0:
                    if (b != PREAMBLE)
                        close_frame(ST_BAD_START, 8'd0, 8'd0);
                    else
                        phase = PH_SYNC1;
                PH_SYNC1:
                    if (b != START_CODE)
                        close_frame(ST_BAD_START, 8'd0, 8'd0);
                    else
                        phase = PH_LEN;
                PH_LEN:
                begin
                    len_field = b;
                    phase     = PH_LEN_CSUM;
                end
                PH_LEN_CSUM:
                begin
                    tally = b + len_field;
                    if (tally != 8'd0)
                        close_frame(ST_BAD_LCS, 8'd0, 8'd0);
                    else if (body_len() > max_body)
                        close_frame(ST_TOO_LONG, 8'd0, 8'd0);
                    else
                        phase = PH_IDENT;
                end
                PH_IDENT:
                    if (b != want_ident)
                    begin
                        if (b == ERROR_IDENT)
                            phase = PH_ERR_CODE;
                        else
                            close_frame(ST_BAD_TFI, 8'd0, 8'd0);
                    end
                    else
                    begin
                        data_sum   = b;
                        body_count = 8'd0;
                        phase      = (body_len() == 8'd0) ? PH_BODY_CSUM : PH_BODY;
                    end
                PH_ERR_CODE:
                begin
                    err_code = b;
                    phase    = PH_ERR_POST;
                end
                // status goes out whatever the postamble holds
                PH_ERR_POST:
                    close_frame(ST_ERR_FRAME, 8'd0, err_code);
                PH_BODY:
                begin
                    r       = '0;
                    r.data  = b;
                    r.index = body_count;
                    deframed_q.push_back(r);
                    data_sum   = data_sum + b;
                    body_count = body_count + 8'd1;
                    if (body_count >= body_len())
                        phase = PH_BODY_CSUM;
                end
                PH_BODY_CSUM:
                begin
                    tally = b + data_sum;
                    if (tally != 8'd0)
                        close_frame(ST_BAD_DCS, 8'd0, 8'd0);
                    else
                        phase = PH_POSTAMBLE;
                end
                PH_POSTAMBLE:
                    if (b != PREAMBLE)
                        close_frame(ST_BAD_POST, 8'd0, 8'd0);
                    else
                        close_frame(ST_OK, len_field, 8'd0);
                default:
                    phase = PH_IDLE;
            endcase
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        deframed_t seen;
        deframed_t want;
        if (!rst_n)
        begin
            max_body   = MAX_PAYLOAD_RST;
            want_ident = EXPECTED_ID_RST;
            phase      = PH_IDLE;
            len_field  = 8'd0;
            body_count = 8'd0;
            data_sum   = 8'd0;
            err_code   = 8'd0;
            err_total  = 0;
            deframed_q.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_MAX_PAYLOAD: max_body   = cfg_data;
                    REG_EXPECTED_ID: want_ident = cfg_data;
                    default: ;
                endcase
            end

            if (item.valid && item.ready)
                deframe_byte(item.frame_start, item.rx_byte);

            if (result.valid && result.ready)
            begin
                seen.kind   = result.result_kind;
                seen.data   = result.payload_byte;
                seen.index  = result.payload_index;
                seen.status = result.frame_status;
                seen.length = result.frame_length;
                seen.code   = result.fault_code;
                seen.last   = result.is_last;
                if (deframed_q.size() == 0)
                begin
                    err_total++;
                    if (err_total <= REPORT_MAX)
                        $display("%0t: result with nothing expected: kind %0d byte %02h",
                                 $time, seen.kind, seen.data);
                end
                else
                begin
                    want = deframed_q.pop_front();
                    if (seen !== want)
                    begin
                        err_total++;
                        if (err_total <= REPORT_MAX)
                        begin
                            $display("%0t: mismatch, expected kind %0d byte %02h idx %0d",
                                     $time, want.kind, want.data, want.index);
                            $display("    status %0d len %0d code %02h last %0d",
                                     want.status, want.length, want.code, want.last);
                            $display("    got kind %0d byte %02h idx %0d",
                                     seen.kind, seen.data, seen.index);
                            $display("    status %0d len %0d code %02h last %0d",
                                     seen.status, seen.length, seen.code, seen.last);
                        end
                    end
                end
            end

            outstanding <= deframed_q.size();
        end
    end

endmodule

/* verif/nfc_frame_deframer_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfc_frame_deframer_core_tb
// drives byte streams of reader controller frames into the deframer, good ones
// and damaged ones, across several limit and identifier settings with random
// gaps and back-pressure; the checker beside the block scores every result
// ----------------------------------------------------------------------------
module nfc_frame_deframer_core_tb;
    import nfcdf_pkg::*;

    localparam int    HALF_PERIOD   = 6;
    localparam int    RESET_CYCLES  = 10;
    localparam int    HOLD_CYCLES   = 300;
    // leave a comfortable margin for the block's input and result registers
    localparam int    SETTLE_CYCLES = 8;
    localparam int    CYCLE_LIMIT   = 400000;
    localparam byte_t ERROR_IDENT   = 8'h7F;
    localparam byte_t PREAMBLE      = 8'h00;
    localparam byte_t START_CODE    = 8'hFF;
    localparam byte_t POSTAMBLE     = 8'h00;

    // shapes of frame the stimulus can build
    typedef enum int {
        FR_OK,
        FR_EMPTY,
        FR_BAD_START,
        FR_BAD_LCS,
        FR_TOO_LONG,
        FR_BAD_ID,
        FR_ERROR,
        FR_BAD_DCS,
        FR_BAD_POST,
        FR_ABANDON
    } frame_kind_e;

    logic     clk;
    logic     rst_n;
    logic     cfg_write;
    cfg_idx_t cfg_index;
    byte_t    cfg_data;

    int       fail_count;
    int       outstanding;
    int       cycle_count;
    int       items_sent;
    int       src_idle_pct;
    int       sink_stall_pct;
    bit       hold_off_req;

    // the limits currently programmed, so frames can be built to pass or fail
    byte_t    lim_payload;
    byte_t    want_id;

    nfcdf_in_if  in_ch ();
    nfcdf_out_if out_ch ();

    nfc_frame_deframer_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (in_ch),
        .result    (out_ch)
    );

    nfc_frame_deframer_checker u_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .item        (in_ch),
        .result      (out_ch),
        .mismatches  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #HALF_PERIOD clk = ~clk;
    end

    // watchdog: a hung handshake ends the run as a failure
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // result side: random stalls, plus one long hold-off on request so the
    // block backs up and stops taking bytes
    initial
    begin
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off_req <= 1'b0;
            end
            else
            begin
                out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    // one byte transaction, with random idle cycles in front of it;
    // returns on the edge where the byte is taken
    task automatic push_byte(input logic start, input byte_t b);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_ch.valid       <= 1'b0;
            in_ch.frame_start <= 1'($urandom_range(1));
            in_ch.rx_byte     <= byte_t'($urandom);
            @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.frame_start <= start;
        in_ch.rx_byte     <= b;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    // builds one frame against the current settings, damages it as asked
    // and sends it, the first byte flagged as frame start
    task automatic send_frame(input frame_kind_e kind_in);
        frame_kind_e kind;
        byte_t       seq[$];
        byte_t       len_b;
        byte_t       ident;
        byte_t       sum;
        byte_t       b;
        int          cap;
        int          plen;
        int          cut;
        kind = kind_in;
        cap  = (lim_payload > 8'd254) ? 254 : int'(lim_payload);
        // nothing can be too long once the limit covers every length
        if (kind == FR_TOO_LONG && cap == 254)
            kind = FR_BAD_LCS;
        // with 0x7f programmed as identifier an error frame is an ordinary one
        if (kind == FR_ERROR && want_id == ERROR_IDENT)
            kind = FR_OK;

        // mostly short bodies, now and then anything up to the limit
        if (kind == FR_TOO_LONG)
            plen = $urandom_range(254, cap + 1);
        else if (kind == FR_EMPTY)
            plen = 0;
        else if ($urandom_range(15) == 0)
            plen = $urandom_range(cap);
        else
            plen = $urandom_range((cap < 6) ? cap : 6);

        // an empty body may be sent with length byte zero or one
        len_b = (plen == 0 && $urandom_range(1) == 1) ? 8'd0 : byte_t'(plen + 1);
        b     = 8'd0 - len_b;
        seq   = {PREAMBLE, PREAMBLE, START_CODE, len_b, b};

        if (kind == FR_ERROR)
        begin
            // identifier, error code, then a postamble of any value
            seq.push_back(ERROR_IDENT);
            seq.push_back(byte_t'($urandom));
            seq.push_back(byte_t'($urandom));
        end
        else if (kind == FR_BAD_ID)
        begin
            do
                ident = byte_t'($urandom);
            while (ident == want_id || ident == ERROR_IDENT);
            seq.push_back(ident);
        end
        else
        begin
            sum = want_id;
            seq.push_back(want_id);
            repeat (plen)
            begin
                b   = byte_t'($urandom);
                sum = sum + b;
                seq.push_back(b);
            end
            b = 8'd0 - sum;
            seq.push_back(b);
            seq.push_back(POSTAMBLE);
        end

        // damage, and drop what the parser would ignore after the fault
        case (kind)
            FR_BAD_START:
            begin
                cut      = $urandom_range(2);
                seq[cut] = seq[cut] ^ byte_t'($urandom_range(255, 1));
                seq      = seq[0:cut];
            end
            FR_BAD_LCS:
            begin
                seq[4] = seq[4] ^ byte_t'($urandom_range(255, 1));
                seq    = seq[0:4];
            end
            FR_TOO_LONG:
                seq = seq[0:4];
            FR_BAD_ID:
                seq = seq[0:5];
            FR_BAD_DCS:
            begin
                cut      = seq.size() - 2;
                seq[cut] = seq[cut] ^ byte_t'($urandom_range(255, 1));
                seq      = seq[0:cut];
            end
            FR_BAD_POST:
                seq[seq.size() - 1] = byte_t'($urandom_range(255, 1));
            // cut short; the next frame start throws the rest away
            FR_ABANDON:
            begin
                cut = $urandom_range(seq.size() - 2);
                seq = seq[0:cut];
            end
            default: ;
        endcase

        foreach (seq[i])
        begin
            push_byte(i == 0, seq[i]);
            items_sent++;
        end
    endtask

    // sender holds off until every predicted result is out, then lets the
    // block settle since the last bytes may have caused no result
    task automatic wait_drained();
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one phase: program both registers while idle, set the idling mix,
    // then stream random frames with stray bytes in between
    task automatic run_phase(input byte_t max_pl, input byte_t ident, input int src_pct,
                             input int sink_pct, input int count, input bit hold);
        int          target;
        int          r;
        frame_kind_e kind;
        wait_drained();
        lim_payload = max_pl;
        want_id     = ident;
        cfg_write <= 1'b1;
        cfg_index <= REG_MAX_PAYLOAD;
        cfg_data  <= max_pl;
        @(posedge clk);
        cfg_index <= REG_EXPECTED_ID;
        cfg_data  <= ident;
        @(posedge clk);
        cfg_write <= 1'b0;

        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        if (hold)
            hold_off_req <= 1'b1;

        target = items_sent + count;
        while (items_sent < target)
        begin
            r    = $urandom_range(99);
            kind = (r < 35) ? FR_OK :
                   (r < 42) ? FR_EMPTY :
                   (r < 50) ? FR_BAD_START :
                   (r < 58) ? FR_BAD_LCS :
                   (r < 66) ? FR_TOO_LONG :
                   (r < 74) ? FR_BAD_ID :
                   (r < 84) ? FR_ERROR :
                   (r < 90) ? FR_BAD_DCS :
                   (r < 95) ? FR_BAD_POST : FR_ABANDON;
            send_frame(kind);
            // stray bytes without a start flag; usually ignored by the parser
            if ($urandom_range(3) == 0)
                repeat ($urandom_range(3, 1)) push_byte(1'b0, byte_t'($urandom));
        end
        in_ch.valid <= 1'b0;
    endtask

    initial
    begin
        rst_n             <= 1'b0;
        cfg_write         <= 1'b0;
        cfg_index         <= REG_MAX_PAYLOAD;
        cfg_data          <= 8'd0;
        in_ch.valid       <= 1'b0;
        in_ch.frame_start <= 1'b0;
        in_ch.rx_byte     <= 8'd0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_off_req   = 1'b0;
        items_sent     = 0;
        lim_payload    = MAX_PAYLOAD_RST;
        want_id        = EXPECTED_ID_RST;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: start byte that is not a preamble, empty frame, error
        // frame and a good frame, all on the reset settings
        push_byte(1'b1, 8'hFF);
        send_frame(FR_EMPTY);
        send_frame(FR_ERROR);
        send_frame(FR_OK);
        in_ch.valid <= 1'b0;

        // random phases; limits and identifiers include the extremes and 0x7f
        run_phase(8'd64, 8'hD5, 0, 0, 250, 1'b0);
        run_phase(8'd255, ERROR_IDENT, 52, 0, 220, 1'b0);
        run_phase(8'd0, 8'h00, 0, 52, 200, 1'b0);
        run_phase(8'd8, byte_t'($urandom), 17, 17, 200, 1'b1);
        run_phase(byte_t'($urandom), 8'hD5, 52, 52, 200, 1'b0);
        run_phase(8'd255, 8'hFF, 0, 0, 200, 1'b0);

        wait_drained();
        if (fail_count == 0 && outstanding == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
